/* design/asort_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asort_pkg: shared types and constants of the ascending sorter
// Holds the queue tag carried between front and back, the back-end state
// type and the depth of the decoupling queue.
// ----------------------------------------------------------------------------
package asort_pkg;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // control tag that travels with each queued element
    typedef struct packed {
        logic last;  // element closes the set
        logic keep;  // element is stored (set not yet full)
        logic ovf;   // set has dropped an element so far
    } t_tag;

    localparam int TAG_W = $bits(t_tag);

    // back-end sequencer states
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_back_state;

endpackage

/* design/ascending_array_sorter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascending_array_sorter_core: ascending set sorter
// Collects a set of signed values closed by a last flag and returns the set
// in ascending order, flagging overflow when more than DEPTH values came in.
// ----------------------------------------------------------------------------
//  Channel | Handshake     | Payload                             | Direction
//  --------+---------------+-------------------------------------+----------
//  input   | i_push/o_full | i_value, i_last                     | in
//  result  | o_empty/i_pop | o_value_res, o_last_res, o_overflow | out
//
//  Load: one element per cycle while the queue has room; the row inserts each kept element.
//  Drain: a set of n kept elements gives n results, one per cycle while popped.
//  The row takes no new element until the last result of a set is popped; a
//  4-entry queue keeps taking input meanwhile, then o_full rises.
//  Reset (synchronous, active low) empties queue and row and clears counters.
// ----------------------------------------------------------------------------
module ascending_array_sorter_core #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  logic                         i_last,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic signed [DATA_WIDTH-1:0] o_value_res,
    output logic                         o_last_res,
    output logic                         o_overflow
);

    localparam int Q_W = asort_pkg::TAG_W + DATA_WIDTH;

    logic            q_push, q_full, q_pop, q_empty;
    logic [Q_W-1:0]  q_wdata, q_rdata;
    asort_pkg::t_tag q_tag;
    logic signed [DATA_WIDTH-1:0] q_value;

    assign o_full  = q_full;
    assign q_tag   = q_rdata[Q_W-1:DATA_WIDTH];
    assign q_value = q_rdata[DATA_WIDTH-1:0];

    // front: classify and enqueue
    asort_front #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_value  (i_value),
        .i_last   (i_last),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    // decoupling queue
    asort_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // back: sorting row and result drain
    asort_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_valid (!q_empty),
        .i_value       (q_value),
        .i_tag         (q_tag),
        .o_entry_pop   (q_pop),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_value_res   (o_value_res),
        .o_last_res    (o_last_res),
        .o_overflow    (o_overflow)
    );

endmodule

/* design/asort_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asort_fifo: short decoupling queue
// Register-based FIFO of asort_pkg::QUEUE_DEPTH entries; the head entry is
// shown whenever the queue is not empty.
// ----------------------------------------------------------------------------
module asort_fifo #(
    parameter int WIDTH = 35
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (asort_pkg::QUEUE_DEPTH > 1) ? $clog2(asort_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(asort_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [asort_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CNT_W'(asort_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    // pointer and fill count update, wrapping at the queue depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(asort_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(asort_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* design/asort_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asort_front: input classifier
// Counts the elements of the current set, marks those beyond DEPTH as
// dropped, tracks overflow and writes each transaction into the queue.
// ----------------------------------------------------------------------------
module asort_front #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  logic signed [DATA_WIDTH-1:0]      i_value,
    input  logic                              i_last,
    input  logic                              i_q_full,
    output logic                              o_q_push,
    output logic [asort_pkg::TAG_W+DATA_WIDTH-1:0] o_q_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             accept;
    asort_pkg::t_tag  tag;

    assign accept = i_push && !i_q_full;

    // classify the element: stored while the set has room
    always_comb begin
        tag.last = i_last;
        tag.keep = (r_count < CNT_W'(DEPTH));
        tag.ovf  = r_ovf || (r_count >= CNT_W'(DEPTH));
    end

    assign o_q_push = accept;
    assign o_q_data = {tag, i_value};

    // set bookkeeping; a closing element starts a fresh set
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (accept) begin
            if (i_last) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else begin
                if (tag.keep) begin
                    n_count = r_count + 1'b1;
                end
                n_ovf = tag.ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

/* design/asort_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asort_back: insertion sorting chain
// A row of DEPTH compare cells kept in ascending order. Each queued element
// marked to keep is inserted into the row; after the closing element the row
// shifts out smallest first on each pop, cell 0 being the result register.
// ----------------------------------------------------------------------------
module asort_back #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_entry_valid,
    input  logic signed [DATA_WIDTH-1:0] i_value,
    input  asort_pkg::t_tag              i_tag,
    output logic                         o_entry_pop,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic signed [DATA_WIDTH-1:0] o_value_res,
    output logic                         o_last_res,
    output logic                         o_overflow
);

    asort_pkg::t_back_state r_state, n_state;

    logic signed [DATA_WIDTH-1:0] r_cell [DEPTH];
    logic signed [DATA_WIDTH-1:0] n_cell [DEPTH];
    logic [DEPTH-1:0]             r_valid, n_valid;
    logic [DEPTH-1:0]             le;
    logic                         r_ovf;
    logic                         do_insert, do_shift;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            asort_pkg::ST_LOAD: begin
                if (i_entry_valid && i_tag.last) begin
                    n_state = asort_pkg::ST_DRAIN;
                end
            end
            asort_pkg::ST_DRAIN: begin
                if (i_pop && !r_valid[1]) begin
                    n_state = asort_pkg::ST_LOAD;
                end
            end
            default: n_state = asort_pkg::ST_LOAD;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_entry_pop = 1'b0;
        o_empty     = 1'b1;
        do_shift    = 1'b0;
        unique case (r_state)
            asort_pkg::ST_LOAD: begin
                o_entry_pop = i_entry_valid;
            end
            asort_pkg::ST_DRAIN: begin
                o_empty  = 1'b0;
                do_shift = i_pop;
            end
            default: begin
                o_entry_pop = 1'b0;
            end
        endcase
    end

    assign do_insert = o_entry_pop && i_tag.keep;

    // per-cell compare against the incoming element
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            le[i] = r_valid[i] && (r_cell[i] <= i_value);
        end
    end

    // cell update: keep, take the new element, or shift
    always_comb begin
        n_cell  = r_cell;
        n_valid = r_valid;
        if (do_insert) begin
            if (!le[0]) begin
                n_cell[0] = i_value;
            end
            n_valid[0] = 1'b1;
            for (int i = 1; i < DEPTH; i++) begin
                if (!le[i]) begin
                    n_cell[i] = le[i-1] ? i_value : r_cell[i-1];
                end
                n_valid[i] = r_valid[i] || r_valid[i-1];
            end
        end else if (do_shift) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_cell[i]  = r_cell[i+1];
                n_valid[i] = r_valid[i+1];
            end
            n_valid[DEPTH-1] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asort_pkg::ST_LOAD;
            r_valid <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (o_entry_pop && i_tag.last) begin
                r_ovf <= i_tag.ovf;
            end
        end
    end

    // cell payload, no reset
    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    assign o_value_res = r_cell[0];
    assign o_last_res  = !r_valid[1];
    assign o_overflow  = r_ovf;

endmodule
